// File: hw/rtl/looping_clip_byte_mixer_assert.svh
// Assertion helpers for the mixer RTL.
`ifndef LOOPING_CLIP_BYTE_MIXER_ASSERT_SVH
`define LOOPING_CLIP_BYTE_MIXER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lcbm_pkg.sv
package lcbm_pkg;

    // Default clip store depth in bytes.
    localparam int unsigned LCBM_CLIP_DEPTH = 65536;

    // Fixed field widths.
    localparam int unsigned LEN_W    = 17;
    localparam int unsigned CADDR_W  = 16;
    localparam int unsigned SAMPLE_W = 8;

    // Configuration register indexes.
    localparam logic REG_CLIP_LEN = 1'b0;
    localparam logic REG_FORMAT   = 1'b1;

    // Mixing constants on the ten-bit sum.
    localparam logic [9:0] MIX_BIAS = 10'd128;
    localparam logic [9:0] MIX_TOP  = 10'd383;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_MIX  = 1'b1
    } t_op;

    // Classified word handed from the front to the back.
    typedef struct packed {
        t_op                 op;
        logic                wr_en;
        logic                applied;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_cmd;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// File: hw/rtl/lcbm_front.sv
module lcbm_front
    import lcbm_pkg::*;
#(
    parameter int unsigned CLIP_DEPTH = LCBM_CLIP_DEPTH,
    parameter int unsigned AW         = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [LEN_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [CADDR_W-1:0]  i_clip_address,
    input  logic [SAMPLE_W-1:0] i_sample_in,
    input  logic                i_last_in_block,
    input  t_q_stat             i_q_stat,
    output logic                o_push,
    output t_cmd                o_cmd,
    output logic [AW-1:0]       o_addr
);

    localparam logic [31:0] DEPTH_W = 32'(CLIP_DEPTH);

    logic [LEN_W-1:0] r_clip_len;
    logic             r_pcm;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W:0]   pos_inc;
    logic [LEN_W-1:0] pos_sat;
    logic             active;
    logic             accept;
    logic [31:0]      pos_w;
    logic [31:0]      addr_w;
    t_op              op;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_len <= '0;
            r_pcm      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CLIP_LEN: r_clip_len <= i_cfg_data;
                REG_FORMAT:   r_pcm      <= i_cfg_data[0];
                default:      r_pcm      <= r_pcm;
            endcase
        end
    end

    // Classify the word and work out the next play position.
    always_comb begin
        op      = t_op'(i_operation);
        accept  = i_in_valid && !i_q_stat.full;
        len_eff = ({15'd0, r_clip_len} > DEPTH_W) ? DEPTH_W[LEN_W-1:0] : r_clip_len;
        active  = r_pcm && (len_eff != '0);
        pos_inc = {1'b0, r_pos} + 18'd1;
        pos_sat = ({1'b0, len_eff} < pos_inc) ? len_eff : pos_inc[LEN_W-1:0];
        if (i_last_in_block && (pos_sat >= len_eff)) begin
            pos_sat = '0;
        end
        n_pos = r_pos;
        if (accept) begin
            unique case (op)
                OP_LOAD: n_pos = '0;
                OP_MIX:  n_pos = active ? pos_sat : r_pos;
                default: n_pos = r_pos;
            endcase
        end
        pos_w  = {15'd0, r_pos};
        addr_w = {16'd0, i_clip_address};
        o_cmd.op      = op;
        o_cmd.wr_en   = (op == OP_LOAD) && (addr_w < DEPTH_W);
        o_cmd.applied = (op == OP_MIX) && active && (r_pos < len_eff);
        o_cmd.sample  = i_sample_in;
        o_cmd.last    = i_last_in_block;
        o_addr        = (op == OP_LOAD) ? addr_w[AW-1:0] : pos_w[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_push     = accept;
    assign o_in_ready = !i_q_stat.full;

endmodule

// File: hw/rtl/lcbm_queue.sv
module lcbm_queue
    import lcbm_pkg::*;
#(
    parameter int unsigned AW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_addr,
    input  logic          i_pop,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_addr,
    output t_q_stat       o_stat
);

    localparam int unsigned EW = $bits(t_cmd) + AW;

    logic [EW-1:0] r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    // Two-entry queue; payload entries need no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= {i_cmd, i_addr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign {o_cmd, o_addr} = r_ent[r_rp];
    assign o_stat.full     = (r_cnt == 2'd2);
    assign o_stat.empty    = (r_cnt == 2'd0);

endmodule

// File: hw/rtl/lcbm_back.sv
module lcbm_back
    import lcbm_pkg::*;
#(
    parameter int unsigned CLIP_DEPTH = LCBM_CLIP_DEPTH,
    parameter int unsigned AW         = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [AW-1:0]       i_addr,
    input  t_q_stat             i_q_stat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SAMPLE_W-1:0] o_sample_out,
    output logic                o_clip_applied,
    output logic                o_block_end
);

    logic [SAMPLE_W-1:0] r_mem [CLIP_DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;
    logic                r_s1_vld;
    logic [SAMPLE_W-1:0] r_s1_sample;
    logic                r_s1_applied;
    logic                r_s1_last;
    logic                r_o_vld;
    logic [SAMPLE_W-1:0] r_o_sample;
    logic                r_o_applied;
    logic                r_o_last;
    logic                s2_free;
    logic                s1_free;
    logic                is_mix;
    logic [9:0]          sum;
    logic [9:0]          diff;
    logic [SAMPLE_W-1:0] mixed;

    assign s2_free = !r_o_vld || i_out_ready;
    assign s1_free = !r_s1_vld || s2_free;
    assign o_pop   = !i_q_stat.empty && s1_free;
    assign is_mix  = (i_cmd.op == OP_MIX);

    // Clip store: a load writes, a mix reads the byte at the play position.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.wr_en) begin
            r_mem[i_addr] <= i_cmd.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    // Read stage: holds the mix word alongside its clip byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_free) begin
            r_s1_vld <= o_pop && is_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_sample  <= i_cmd.sample;
            r_s1_applied <= i_cmd.applied;
            r_s1_last    <= i_cmd.last;
        end
    end

    // Add with bias removed, clamped to the byte range.
    always_comb begin
        sum  = {2'b00, r_s1_sample} + {2'b00, r_rdata};
        diff = sum - MIX_BIAS;
        priority if (sum < MIX_BIAS) begin
            mixed = '0;
        end else if (sum > MIX_TOP) begin
            mixed = '1;
        end else begin
            mixed = diff[SAMPLE_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s2_free) begin
            r_o_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && r_s1_vld) begin
            r_o_sample  <= r_s1_applied ? mixed : r_s1_sample;
            r_o_applied <= r_s1_applied;
            r_o_last    <= r_s1_last;
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_sample_out   = r_o_sample;
    assign o_clip_applied = r_o_applied;
    assign o_block_end    = r_o_last;

endmodule

// File: hw/rtl/looping_clip_byte_mixer.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    operation, clip_address, sample_in, last_in_block
// output    o_out_valid / i_out_ready  sample_out, clip_applied, block_end
// config    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One word per cycle is accepted while the queue has room; a mix result passes the
// queue, read stage and output register. The play position updates at acceptance,
// which sets the rate. Load words write the clip store and yield no result.
// Synchronous active-low reset clears control state; the clip store is not cleared.
// A two-entry queue lets the front accept while the output is stalled, until it is full.
`include "looping_clip_byte_mixer_assert.svh"

module looping_clip_byte_mixer
    import lcbm_pkg::*;
#(
    parameter int unsigned CLIP_DEPTH = LCBM_CLIP_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [LEN_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [CADDR_W-1:0]  i_clip_address,
    input  logic [SAMPLE_W-1:0] i_sample_in,
    input  logic                i_last_in_block,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SAMPLE_W-1:0] o_sample_out,
    output logic                o_clip_applied,
    output logic                o_block_end
);

    localparam int unsigned AW = (CLIP_DEPTH > 1) ? $clog2(CLIP_DEPTH) : 1;

    logic          push;
    logic          pop;
    t_cmd          f_cmd;
    logic [AW-1:0] f_addr;
    t_cmd          q_cmd;
    logic [AW-1:0] q_addr;
    t_q_stat       q_stat;

    // Front: accepts and classifies words, tracks the play position.
    lcbm_front #(
        .CLIP_DEPTH (CLIP_DEPTH),
        .AW         (AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_clip_address  (i_clip_address),
        .i_sample_in     (i_sample_in),
        .i_last_in_block (i_last_in_block),
        .i_q_stat        (q_stat),
        .o_push          (push),
        .o_cmd           (f_cmd),
        .o_addr          (f_addr)
    );

    // Queue between front and back.
    lcbm_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_addr  (f_addr),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr),
        .o_stat  (q_stat)
    );

    // Back: clip store access, mixing and the output register.
    lcbm_back #(
        .CLIP_DEPTH (CLIP_DEPTH),
        .AW         (AW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_cmd),
        .i_addr         (q_addr),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sample_out   (o_sample_out),
        .o_clip_applied (o_clip_applied),
        .o_block_end    (o_block_end)
    );

    // Queue bookkeeping checks.
    `LCBM_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "push into a full queue")
    `LCBM_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from an empty queue")
    `LCBM_ASSERT_NOW(a_stall_means_data, !o_in_ready, !q_stat.empty, "input stalled with empty queue")
    `LCBM_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty, "pushed word lost from queue")

endmodule

// File: dv/looping_clip_byte_mixer_tb.sv
module looping_clip_byte_mixer_tb;
    import lcbm_pkg::*;

    localparam int unsigned HALF_PERIOD   = 4;
    localparam int unsigned RESET_CYCLES  = 4;
    // Pipeline depth plus the two-entry queue, with margin.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned PHASE_WORDS   = 105;
    localparam int unsigned PRELOAD_WORDS = 256;
    localparam int unsigned NUM_PHASES    = 9;
    localparam int          MIX_OFFSET    = 128;
    localparam int          BYTE_MAX      = 255;

    typedef enum {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                applied;
        logic                block_end;
    } t_mix_word;

    // Tracks the clip store, play position and registers, and holds the
    // mixed words that are still due from the block.
    class mixer_scoreboard;
        bit [SAMPLE_W-1:0] clip_store [LCBM_CLIP_DEPTH];
        bit                written [LCBM_CLIP_DEPTH];
        int unsigned       position = 0;
        int unsigned       clip_len = 0;
        bit                pcm_on = 1'b1;
        t_mix_word         pending_mixes [$];
        int unsigned       mismatches = 0;

        function int unsigned active_length();
            return (clip_len > LCBM_CLIP_DEPTH) ? LCBM_CLIP_DEPTH : clip_len;
        endfunction

        // True when the next mix word would read a clip byte never loaded.
        function bit mix_hits_unwritten();
            int unsigned len;
            len = active_length();
            return pcm_on && len != 0 && position < len && !written[position];
        endfunction

        function void write_reg(logic idx, logic [LEN_W-1:0] data);
            if (idx == REG_CLIP_LEN) begin
                clip_len = data;
            end else if (idx == REG_FORMAT) begin
                pcm_on = data[0];
            end
        endfunction

        function void accept_word(t_op op, logic [CADDR_W-1:0] addr,
                                  logic [SAMPLE_W-1:0] smp, logic last);
            int unsigned len;
            int unsigned nxt;
            int          mixed;
            t_mix_word   res;
            len = active_length();
            res.sample    = smp;
            res.applied   = 1'b0;
            res.block_end = last;
            // A load always lands inside the store at the default depth and
            // restarts playback.
            if (op == OP_LOAD) begin
                clip_store[addr] = smp;
                written[addr]    = 1'b1;
                position         = 0;
                return;
            end
            if (pcm_on && len != 0) begin
                if (position < len) begin
                    mixed = int'(smp) + int'(clip_store[position]) - MIX_OFFSET;
                    if (mixed < 0) begin
                        mixed = 0;
                    end
                    if (mixed > BYTE_MAX) begin
                        mixed = BYTE_MAX;
                    end
                    res.sample  = SAMPLE_W'(mixed);
                    res.applied = 1'b1;
                end
                // Advance, saturate at the length, and loop on a block end that reaches it.
                nxt = position + 1;
                if (nxt > len) begin
                    nxt = len;
                end
                if (last && nxt >= len) begin
                    nxt = 0;
                end
                position = nxt;
            end
            pending_mixes.push_back(res);
        endfunction

        function void check_result(logic [SAMPLE_W-1:0] smp, logic applied,
                                   logic block_end);
            t_mix_word exp_word;
            if (pending_mixes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected output word: sample %02h applied %0b end %0b",
                             smp, applied, block_end);
                end
                return;
            end
            exp_word = pending_mixes.pop_front();
            if (exp_word.sample !== smp || exp_word.applied !== applied ||
                exp_word.block_end !== block_end) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("output mismatch: expected sample %02h applied %0b end %0b, %s",
                             exp_word.sample, exp_word.applied, exp_word.block_end,
                             $sformatf("got sample %02h applied %0b end %0b",
                                       smp, applied, block_end));
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_idx = REG_CLIP_LEN;
    logic [LEN_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_operation = OP_LOAD;
    logic [CADDR_W-1:0]  i_clip_address = '0;
    logic [SAMPLE_W-1:0] i_sample_in = '0;
    logic                i_last_in_block = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [SAMPLE_W-1:0] o_sample_out;
    logic                o_clip_applied;
    logic                o_block_end;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     quiet_cycles = 0;
    mixer_scoreboard sb = new();

    // Clip settings visited by the random part, extremes included.
    int unsigned phase_len [NUM_PHASES] = '{16, 200, 1, 0, 65536, 37, 5, 131071, 64};
    bit          phase_pcm [NUM_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1, 1};

    looping_clip_byte_mixer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_clip_address  (i_clip_address),
        .i_sample_in     (i_sample_in),
        .i_last_in_block (i_last_in_block),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sample_out    (o_sample_out),
        .o_clip_applied  (o_clip_applied),
        .o_block_end     (o_block_end)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // The receiver stalls at random on every falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Observe every handshake at the rising edge; the watchdog ends a run
    // in which nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_sample_out, o_clip_applied, o_block_end);
            end
            if (i_in_valid && o_in_ready) begin
                sb.accept_word(t_op'(i_operation), i_clip_address, i_sample_in,
                               i_last_in_block);
            end
            if (i_cfg_we) begin
                sb.write_reg(i_cfg_idx, i_cfg_data);
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic void set_idling(t_idle_mode mode);
        case (mode)
            IDLE_RX_HEAVY: begin
                send_idle_pct = 8;
                recv_idle_pct = 47;
            end
            IDLE_TX_HEAVY: begin
                send_idle_pct = 47;
                recv_idle_pct = 8;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endfunction

    // Called on a falling edge; returns on the falling edge after acceptance.
    task automatic send_word(input t_op op, input logic [CADDR_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] smp, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_clip_address  <= addr;
        i_sample_in     <= smp;
        i_last_in_block <= last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // A mix word that would read an empty clip slot is preceded by a load
    // of that slot, which also sends playback back to the start.
    task automatic send_mix(input logic [SAMPLE_W-1:0] smp, input logic last);
        if (sb.mix_hits_unwritten()) begin
            send_word(OP_LOAD, CADDR_W'(sb.position), SAMPLE_W'($urandom_range(255)), 1'b0);
        end
        send_word(OP_MIX, CADDR_W'($urandom_range(65535)), smp, last);
    endtask

    // Hold the input idle until every mixed word is out, then let any load
    // still inside the pipeline settle.
    task automatic wait_for_mixes();
        i_in_valid <= 1'b0;
        while (sb.pending_mixes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [LEN_W-1:0] data);
        wait_for_mixes();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed blocks of mix words, with loads and stray words.
    task automatic run_phase(input int unsigned len, input bit pcm, input t_idle_mode mode,
                             input int unsigned n_words);
        int unsigned sent;
        int unsigned span;
        int unsigned blk;
        int unsigned roll;
        sent = 0;
        write_register(REG_CLIP_LEN, LEN_W'(len));
        write_register(REG_FORMAT, LEN_W'(pcm));
        set_idling(mode);
        span = (len == 0 || len > 40) ? 40 : len + 3;
        while (sent < n_words) begin
            roll = $urandom_range(99);
            if (roll == 0) begin
                wait_for_mixes();
            end else if (roll < 9) begin
                if ($urandom_range(1) == 0) begin
                    send_word(OP_LOAD, CADDR_W'($urandom_range(PRELOAD_WORDS - 1)),
                              SAMPLE_W'($urandom_range(255)), 1'($urandom_range(1)));
                end else begin
                    send_word(OP_LOAD, CADDR_W'($urandom_range(65535)),
                              SAMPLE_W'($urandom_range(255)), 1'($urandom_range(1)));
                end
                sent++;
            end else if (roll < 13) begin
                send_mix(SAMPLE_W'($urandom_range(255)), 1'($urandom_range(1)));
                sent++;
            end else begin
                blk = $urandom_range(1, span);
                for (int unsigned k = 0; k < blk; k++) begin
                    send_mix(SAMPLE_W'($urandom_range(255)), k == blk - 1);
                end
                sent += blk;
            end
        end
    endtask

    initial begin
        set_idling(IDLE_RX_HEAVY);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With no clip length after reset, words pass straight through.
        send_mix(8'h00, 1'b0);
        send_mix(8'hFF, 1'b1);

        // A short clip with the extreme byte values, and the top address.
        send_word(OP_LOAD, 16'h0000, 8'h00, 1'b0);
        send_word(OP_LOAD, 16'h0001, 8'hFF, 1'b1);
        send_word(OP_LOAD, 16'h0002, 8'h80, 1'b0);
        send_word(OP_LOAD, 16'h0003, 8'h7F, 1'b0);
        send_word(OP_LOAD, 16'hFFFF, 8'hA5, 1'b0);
        write_register(REG_CLIP_LEN, LEN_W'(4));

        // Clamp at zero and at full scale, a block end before the clip end,
        // then words past the end until a block end loops playback.
        send_mix(8'h00, 1'b0);
        send_mix(8'hFF, 1'b0);
        send_mix(8'h80, 1'b1);
        send_mix(8'h01, 1'b0);
        send_mix(8'hC3, 1'b0);
        send_mix(8'h3C, 1'b1);
        send_mix(8'h55, 1'b0);

        // A load in mid-clip restarts playback.
        send_word(OP_LOAD, 16'h0002, 8'h10, 1'b0);
        send_mix(8'hAA, 1'b0);

        // Non-PCM format: bytes pass and the position holds.
        write_register(REG_FORMAT, LEN_W'(0));
        send_mix(8'h12, 1'b1);
        write_register(REG_FORMAT, LEN_W'(1));

        // A length beyond the store is clipped to the store depth.
        write_register(REG_CLIP_LEN, {LEN_W{1'b1}});
        send_mix(8'h80, 1'b0);
        send_mix(8'h80, 1'b0);
        send_mix(8'h80, 1'b0);

        // Shrinking the length below the position: pass, then loop.
        write_register(REG_CLIP_LEN, LEN_W'(2));
        send_mix(8'h77, 1'b0);
        send_mix(8'h66, 1'b1);
        send_mix(8'h99, 1'b0);

        // Fill the start of the store before the random part.
        for (int unsigned a = 0; a < PRELOAD_WORDS; a++) begin
            send_word(OP_LOAD, CADDR_W'(a), SAMPLE_W'($urandom_range(255)), 1'b0);
        end

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            run_phase(phase_len[p], phase_pcm[p], t_idle_mode'(p / 3), PHASE_WORDS);
        end

        wait_for_mixes();
        if (sb.mismatches == 0 && sb.pending_mixes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lcbm_pkg.sv
hw/rtl/lcbm_front.sv
hw/rtl/lcbm_queue.sv
hw/rtl/lcbm_back.sv
hw/rtl/looping_clip_byte_mixer.sv
dv/looping_clip_byte_mixer_tb.sv
